// ----- hw/rtl/sorted_priority_queue_top_assert.svh -----
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted priority queue: check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue: check failed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] item_data;
    logic signed [15:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_data;
    logic [OCC_W-1:0]   occupancy;
  } out_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, shifts back on insert, forward on remove.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  logic               occupied,
  input  logic               prev_ge,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               ge,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign ge    = occupied && (entry_r.prio >= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq && !ge) begin
      entry_nxt = prev_ge ? new_entry : prev_entry;
    end else if (ctl.deq) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// Sorted priority queue top level: handshake, fill count, result register and cell chain.
// Holds up to CAPACITY entries in a chain of slot cells, highest priority at the head, ties
// kept in arrival order. For every request, enqueue or dequeue, all cells compare the new
// priority in parallel and shift back or forward together, and the result appears in the
// output register the cycle after acceptance. in_ready is high whenever the output register
// is empty or being taken, so one request per cycle is sustained while the receiver takes
// each result. The parallel priority compare and the fill count update set the critical
// path. An enqueue on a full queue reports full and leaves the contents alone; a dequeue
// on an empty queue reports empty with removed_data zero.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_data
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_t             out_r;
  out_t             out_nxt;

  logic      acc;
  logic      full;
  logic      empty;
  logic      enq_en;
  logic      deq_en;
  cell_ctl_t ctl;
  entry_t    new_entry;

  logic   [CAPACITY-1:0] occupied;
  logic   [CAPACITY:0]   ge_chain;
  entry_t                cell_entry [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign enq_en   = acc && (in_data.operation == OP_ENQ) && !full;
  assign deq_en   = acc && (in_data.operation == OP_DEQ) && !empty;

  assign ctl.enq        = enq_en;
  assign ctl.deq        = deq_en;
  assign new_entry.data = in_data.item_data;
  assign new_entry.prio = in_data.item_priority;
  assign ge_chain[0]    = 1'b1;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;

      assign occupied[i] = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_first
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = cell_entry[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .occupied   (occupied[i]),
        .prev_ge    (ge_chain[i]),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .ge         (ge_chain[i+1]),
        .entry      (cell_entry[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (enq_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt              = out_r;
    out_nxt.removed_data = '0;
    out_nxt.occupancy    = OCC_W'(count_nxt);
    if (in_data.operation == OP_ENQ) begin
      out_nxt.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      out_nxt.status = ST_EMPTY;
    end else begin
      out_nxt.status       = ST_REMOVED;
      out_nxt.removed_data = cell_entry[0].data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SPQ_ASSERT_NEXT(a_enq_count, enq_en, count_r == $past(count_r) + CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_deq_count, deq_en, count_r == $past(count_r) - CNT_W'(1))
  `SPQ_ASSERT_NEXT(a_result_loaded, acc, out_valid_r && (out_r.occupancy == OCC_W'(count_r)))

endmodule

// ----- test/sorted_priority_queue_top_test.sv -----
// Self-checking testbench for the sorted priority queue: directed and random requests.
`timescale 1ns / 100ps

module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  entry_t shadow_slots [CAPACITY];
  int shadow_fill = 0;
  out_t awaited_responses [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int receiver_hold = 0;
  bit no_idle = 1'b0;

  sorted_priority_queue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (receiver_hold > 0) begin
      receiver_hold--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 13);
    end
  end

  function automatic out_t apply_queue_request(in_t req);
    out_t res;
    int slot;
    int i;
    res = '0;
    if (req.operation == OP_ENQ) begin
      if (shadow_fill >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        slot = 0;
        while (slot < shadow_fill &&
               $signed(shadow_slots[slot].prio) >= $signed(req.item_priority)) begin
          slot++;
        end
        for (i = shadow_fill; i > slot; i--) begin
          shadow_slots[i] = shadow_slots[i - 1];
        end
        shadow_slots[slot].data = req.item_data;
        shadow_slots[slot].prio = req.item_priority;
        shadow_fill++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_data = shadow_slots[0].data;
        for (i = 1; i < shadow_fill; i++) begin
          shadow_slots[i - 1] = shadow_slots[i];
        end
        shadow_fill--;
        res.status = ST_REMOVED;
      end
    end
    res.occupancy = OCC_W'(shadow_fill);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response, expected none, actual %h", $time, out_data);
      end else begin
        check_field("status", 32'(awaited_responses[0].status), 32'(out_data.status));
        check_field("removed_data", awaited_responses[0].removed_data, out_data.removed_data);
        check_field("occupancy", 32'(awaited_responses[0].occupancy), 32'(out_data.occupancy));
        void'(awaited_responses.pop_front());
      end
    end
  end

  task automatic send_request(logic op, logic [31:0] data, logic [15:0] prio);
    in_t req;
    req.operation = op;
    req.item_data = data;
    req.item_priority = prio;
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    awaited_responses.push_back(apply_queue_request(req));
  endtask

  task automatic test_empty_dequeue();
    send_request(OP_DEQ, 32'h7fff_ffff, 16'h7fff);
    send_request(OP_DEQ, 32'h8000_0000, 16'h8000);
  endtask

  task automatic test_fill_to_capacity();
    logic [15:0] prios [CAPACITY];
    logic [31:0] words [CAPACITY];
    int i;
    prios = '{16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000,
              16'h0000, 16'h1234, 16'hfffe, 16'h7ffe, 16'h8001, 16'h0001, 16'h0000, 16'hffff};
    words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h1111_1111,
              32'h2222_2222, 32'h3333_3333, 32'h4444_4444, 32'h5555_5555, 32'haaaa_aaaa,
              32'h6666_6666, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999, 32'hcccc_cccc,
              32'hdddd_dddd};
    for (i = 0; i < CAPACITY; i++) begin
      send_request(OP_ENQ, words[i], prios[i]);
    end
    send_request(OP_ENQ, 32'hffff_ffff, 16'h7fff);
  endtask

  task automatic test_dequeue_order();
    repeat (4) send_request(OP_DEQ, 32'h0, 16'h0);
  endtask

  task automatic test_output_backpressure();
    receiver_hold = 60;
    repeat (20) send_request(($urandom_range(99) < 70) ? OP_ENQ : OP_DEQ, $urandom,
                             16'($urandom));
  endtask

  task automatic test_random_traffic(int count);
    int n;
    int enq_pct;
    logic [15:0] prio;
    logic op;
    enq_pct = 50;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      no_idle = (n >= 150 && n < 250);
      op = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
      case ($urandom_range(3))
        0: prio = 16'($urandom_range(6)) - 16'd3;
        1: begin
          case ($urandom_range(3))
            0: prio = 16'h8000;
            1: prio = 16'h7fff;
            2: prio = 16'h0000;
            default: prio = 16'hffff;
          endcase
        end
        default: prio = 16'($urandom);
      endcase
      send_request(op, $urandom, prio);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_dequeue();
    test_fill_to_capacity();
    test_dequeue_order();
    test_output_backpressure();
    test_random_traffic(RANDOM_REQUESTS);
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
